// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PRD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/prd_pkg.sv =====
// Types and constants shared by the PCX run-length pixel decoder.
`default_nettype none

package prd_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_STRIDE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_PIXEL       = 3'd0;
   localparam logic [2:0] STATUS_ZERO_RUN    = 3'd1;
   localparam logic [2:0] STATUS_TRUNC_RUN   = 3'd2;
   localparam logic [2:0] STATUS_OVERFLOW    = 3'd3;
   localparam logic [2:0] STATUS_TRUNC_IMAGE = 3'd4;

   // Run prefix marker and count field.
   localparam logic [7:0] RUN_MARK  = 8'hc0;
   localparam logic [7:0] RUN_COUNT = 8'h3f;

   // Largest height that counts.
   localparam logic [16:0] MAX_HEIGHT = 17'h10000;

   // Geometry derived from the configuration registers.
   typedef struct packed {
      logic [15:0] stride;
      logic [15:0] visible;
      logic [31:0] total;
   } prd_geom_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_WAIT_GEOM,
      ST_LOAD,
      ST_IDLE,
      ST_EXPAND,
      ST_FINISH,
      ST_FAULT
   } prd_state_type;

endpackage

`default_nettype wire

// ===== rtl/prd_if.sv =====
// Handshake channels for compressed input bytes and decoded results.
`default_nettype none

interface prd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface prd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_value;
   logic       image_end;
   logic [2:0] status;
   logic       run_last;

   modport source (output valid, output pixel_value, output image_end, output status,
                   output run_last, input ready);
   modport sink   (input valid, input pixel_value, input image_end, input status,
                   input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/prd_geometry.sv =====
// Configuration registers and the image geometry derived from them.
`default_nettype none

module prd_geometry
   import prd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output prd_geom_type                geom
);

   logic [16:0]  width_ff, width_in;
   logic [15:0]  stride_ff, stride_in;
   logic [16:0]  height_ff, height_in;
   logic [15:0]  visible_ff, visible_in;
   logic [31:0]  total_ff, total_in;
   logic [16:0]  height_clamp;
   logic [32:0]  product;

   // Register writes.
   always_comb begin
      width_in  = width_ff;
      stride_in = stride_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_write_data;
            REG_LINE_STRIDE:  stride_in = csr_write_data[15:0];
            REG_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // Total byte count and visible columns, registered after the multiplier.
   assign height_clamp = (height_ff > MAX_HEIGHT) ? MAX_HEIGHT : height_ff;
   assign product      = 33'(height_clamp) * 33'(stride_ff);
   assign total_in     = product[31:0];
   assign visible_in   = (width_ff < 17'(stride_ff)) ? width_ff[15:0] : stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 17'd1;
         stride_ff <= 16'd1;
         height_ff <= 17'd1;
      end else begin
         width_ff  <= width_in;
         stride_ff <= stride_in;
         height_ff <= height_in;
      end
      visible_ff <= visible_in;
      total_ff   <= total_in;
   end

   assign geom.stride  = stride_ff;
   assign geom.visible = visible_ff;
   assign geom.total   = total_ff;

endmodule

`default_nettype wire

// ===== rtl/pcx_rle_pixel_decoder.sv =====
// Top level of the PCX 8-bit run-length pixel decoder.
//
// The req channel takes one compressed byte per item, with final_byte set on
// the last byte before the palette. The rsp channel gives one item per
// visible pixel, plus one item with a nonzero status on a decoding error.
// run_last marks the last item caused by one input byte.
// A sequencer drives one column/byte counter unit through a run, one decoded
// byte per cycle unless rsp stalls. A run prefix is taken in ST_IDLE; a
// literal or run byte passes ST_EXPAND, one step per decoded byte, and then
// ST_FINISH before req is ready again. The first pixel of a byte reaches
// rsp via the holding and then the output register; errors go via ST_FAULT.
// Bytes after completion or an error are accepted and give no item.
// After reset, and after every register write, req is not ready while the
// geometry settles in ST_WAIT_GEOM and ST_LOAD; the decoder then restarts.
// When rsp stalls, one decoded pixel waits in the output register and one in
// a holding register; the run then stops until rsp drains.
`default_nettype none

module pcx_rle_pixel_decoder
   import prd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   prd_req_if.sink                     req_chan,
   prd_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   prd_geom_type  geom;
   prd_state_type state_ff, state_in;

   logic        run_pending_ff, run_pending_in;
   logic [5:0]  run_length_ff, run_length_in;
   logic [15:0] column_ff, column_in;
   logic [31:0] remain_ff, remain_in;
   logic        done_ff, done_in;
   logic        error_ff, error_in;
   logic [5:0]  count_ff, count_in;
   logic [7:0]  byte_ff, byte_in;
   logic        final_ff, final_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  held_pixel_ff, held_pixel_in;
   logic        held_end_ff, held_end_in;
   logic [2:0]  fault_code_ff, fault_code_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_pixel_ff, rsp_pixel_in;
   logic        rsp_end_ff, rsp_end_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        accept;
   logic        out_free;
   logic        visible;
   logic [16:0] column_inc;
   logic [5:0]  run_count;
   logic        truncated;

   prd_geometry u_geometry (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .geom           (geom)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Column unit: visibility, next column and per-line wrap.
   assign visible    = (column_ff < geom.visible);
   assign column_inc = 17'(column_ff) + 17'd1;
   assign run_count  = run_pending_ff ? run_length_ff : 6'd1;
   assign truncated  = (remain_ff != 32'd0) && final_ff;

   // Sequencer next state and datapath control.
   always_comb begin
      state_in       = state_ff;
      run_pending_in = run_pending_ff;
      run_length_in  = run_length_ff;
      column_in      = column_ff;
      remain_in      = remain_ff;
      done_in        = done_ff;
      error_in       = error_ff;
      count_in       = count_ff;
      byte_in        = byte_ff;
      final_in       = final_ff;
      held_valid_in  = held_valid_ff;
      held_pixel_in  = held_pixel_ff;
      held_end_in    = held_end_ff;
      fault_code_in  = fault_code_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_pixel_in   = rsp_pixel_ff;
      rsp_end_in     = rsp_end_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_WAIT_GEOM: begin
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            remain_in      = geom.total;
            done_in        = (geom.total == 32'd0);
            error_in       = 1'b0;
            run_pending_in = 1'b0;
            run_length_in  = 6'd0;
            column_in      = 16'd0;
            held_valid_in  = 1'b0;
            state_in       = ST_IDLE;
         end

         ST_IDLE: begin
            if (accept && !done_ff && !error_ff) begin
               if (!run_pending_ff && ((req_chan.data_byte & RUN_MARK) == RUN_MARK)) begin
                  // Run prefix: check it, then wait for the byte to repeat.
                  if ((req_chan.data_byte & RUN_COUNT) == 8'd0) begin
                     fault_code_in = STATUS_ZERO_RUN;
                     state_in      = ST_FAULT;
                  end else if (req_chan.final_byte) begin
                     fault_code_in = STATUS_TRUNC_RUN;
                     state_in      = ST_FAULT;
                  end else begin
                     run_pending_in = 1'b1;
                     run_length_in  = req_chan.data_byte[5:0];
                  end
               end else begin
                  run_pending_in = 1'b0;
                  run_length_in  = 6'd0;
                  if (32'(run_count) > remain_ff) begin
                     fault_code_in = STATUS_OVERFLOW;
                     state_in      = ST_FAULT;
                  end else begin
                     count_in = run_count;
                     byte_in  = req_chan.data_byte;
                     final_in = req_chan.final_byte;
                     state_in = ST_EXPAND;
                  end
               end
            end
         end

         ST_EXPAND: begin
            // One decoded byte per cycle; stall only when a pixel has nowhere to go.
            if (!(visible && held_valid_ff && !out_free)) begin
               if (visible) begin
                  if (held_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_pixel_in  = held_pixel_ff;
                     rsp_end_in    = held_end_ff;
                     rsp_status_in = STATUS_PIXEL;
                     rsp_last_in   = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_pixel_in = byte_ff;
                  held_end_in   = (column_inc == 17'(geom.visible)) &&
                                  (remain_ff == 32'(geom.stride - column_ff));
               end
               remain_in = remain_ff - 32'd1;
               column_in = (column_inc >= 17'(geom.stride)) ? 16'd0 : column_inc[15:0];
               count_in  = count_ff - 6'd1;
               if (count_ff == 6'd1) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            // Release the last pixel of this byte, then any truncation error.
            if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_pixel_in  = held_pixel_ff;
                  rsp_end_in    = held_end_ff;
                  rsp_status_in = STATUS_PIXEL;
                  rsp_last_in   = !truncated;
                  held_valid_in = 1'b0;
               end
               done_in = (remain_ff == 32'd0);
               if (truncated) begin
                  fault_code_in = STATUS_TRUNC_IMAGE;
                  state_in      = ST_FAULT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FAULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pixel_in   = 8'd0;
               rsp_end_in     = 1'b0;
               rsp_status_in  = fault_code_ff;
               rsp_last_in    = 1'b1;
               error_in       = 1'b1;
               run_pending_in = 1'b0;
               run_length_in  = 6'd0;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_WAIT_GEOM;
         end
      endcase

      // A register write restarts decoding once the geometry has settled.
      if (csr_write_en && (csr_index <= REG_IMAGE_HEIGHT)) begin
         state_in = ST_WAIT_GEOM;
      end
   end

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_WAIT_GEOM;
         run_pending_ff <= 1'b0;
         done_ff        <= 1'b0;
         error_ff       <= 1'b0;
         held_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         run_pending_ff <= run_pending_in;
         done_ff        <= done_in;
         error_ff       <= error_in;
         held_valid_ff  <= held_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      run_length_ff <= run_length_in;
      column_ff     <= column_in;
      remain_ff     <= remain_in;
      count_ff      <= count_in;
      byte_ff       <= byte_in;
      final_ff      <= final_in;
      held_pixel_ff <= held_pixel_in;
      held_end_ff   <= held_end_in;
      fault_code_ff <= fault_code_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_value = rsp_pixel_ff;
   assign rsp_chan.image_end   = rsp_end_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.run_last    = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/prd_checker.sv =====
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module prd_checker
   import prd_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_pixel_value,
   input wire logic       rsp_image_end,
   input wire logic [2:0] rsp_status,
   input wire logic       rsp_run_last
);

   // A stalled result item holds.
   `PRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_value) && $stable(rsp_status) && $stable(rsp_run_last) && $stable(rsp_image_end), "stalled result item changed")

   // An error item carries no pixel and closes its byte.
   `PRD_ASSERT_NOW(a_error_shape, clock, reset, rsp_valid && (rsp_status != STATUS_PIXEL), (rsp_pixel_value == 8'd0) && !rsp_image_end && rsp_run_last, "malformed error item")

   // The last pixel of the image is a plain pixel item. A truncation error may still follow it
   // when its byte carries the final flag and padding remains.
   `PRD_ASSERT_NOW(a_end_last, clock, reset, rsp_valid && rsp_image_end, rsp_status == STATUS_PIXEL, "image end not on a pixel item")

   // Nothing follows directly behind a delivered error item.
   `PRD_ASSERT_NEXT(a_error_quiet, clock, reset, rsp_valid && rsp_ready && (rsp_status != STATUS_PIXEL), !rsp_valid, "item produced after an error")

endmodule

bind pcx_rle_pixel_decoder prd_checker u_prd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pixel_value (rsp_chan.pixel_value),
   .rsp_image_end   (rsp_chan.image_end),
   .rsp_status      (rsp_chan.status),
   .rsp_run_last    (rsp_chan.run_last)
);

`default_nettype wire

// ===== tb/pcx_rle_pixel_decoder_test.sv =====
// Self-checking testbench for the PCX run-length pixel decoder.
`timescale 1ns / 1ps

module pcx_rle_pixel_decoder_test
   import prd_pkg::*;
();

   // One decoded result item as the rsp channel carries it.
   typedef struct packed {
      logic [7:0] pixel;
      logic       img_end;
      logic [2:0] status;
      logic       run_last;
   } pixel_item_type;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_GEOM} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [7:0]     data;
      logic           fin;
      int             n_typed;
      pixel_item_type typed_item;
      logic [16:0]    w;
      logic [16:0]    s;
      logic [16:0]    h;
   } plan_row_type;

   typedef enum int {
      FAULT_NONE, FAULT_ZERO_RUN, FAULT_TRUNC_RUN, FAULT_OVERFLOW, FAULT_EARLY_FINAL
   } fault_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   prd_req_if req_if ();
   prd_rsp_if rsp_if ();

   pcx_rle_pixel_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #6 clock = ~clock;

   // Shadow copy of the decoder's geometry and decoding state.
   logic [16:0] geo_width;
   logic [15:0] geo_stride;
   logic [16:0] geo_height;
   logic        pend_run;
   logic [5:0]  pend_count;
   logic [15:0] col_pos;
   logic [31:0] left_bytes;
   logic        img_complete;
   logic        err_latched;

   pixel_item_type new_pixels[$];
   pixel_item_type expected_pixels[$];
   plan_row_type   plan[$];

   int  mismatches = 0;
   int  bytes_sent = 0;
   int  burst_left = 0;
   bit  hold_off_request = 1'b0;

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Restart decoding from the current geometry, as any register write does.
   function automatic void restart_image();
      longint unsigned lines;
      lines = (geo_height > MAX_HEIGHT) ? MAX_HEIGHT : geo_height;
      pend_run     = 1'b0;
      pend_count   = '0;
      col_pos      = '0;
      left_bytes   = 32'(lines * geo_stride);
      img_complete = (left_bytes == 0);
      err_latched  = 1'b0;
   endfunction

   function automatic void set_register(input logic [CSR_INDEX_W-1:0] idx,
                                        input logic [16:0] value);
      case (idx)
         REG_IMAGE_WIDTH:  geo_width  = value;
         REG_LINE_STRIDE:  geo_stride = value[15:0];
         REG_IMAGE_HEIGHT: geo_height = value;
         default: return;
      endcase
      restart_image();
   endfunction

   // An error gives one status item and stops decoding until a restart.
   function automatic void flag_error(input logic [2:0] code);
      new_pixels.push_back({8'h00, 1'b0, code, 1'b1});
      err_latched = 1'b1;
      pend_run    = 1'b0;
      pend_count  = '0;
   endfunction

   // Work out the result items that one compressed byte causes.
   function automatic void expand_byte(input logic [7:0] b, input logic fin);
      int unsigned count;
      logic [15:0] vis;
      new_pixels.delete();
      if (img_complete || err_latched) return;
      if (!pend_run && (b & RUN_MARK) == RUN_MARK) begin
         if ((b & RUN_COUNT) == 0) begin
            flag_error(STATUS_ZERO_RUN);
            return;
         end
         if (fin) begin
            flag_error(STATUS_TRUNC_RUN);
            return;
         end
         pend_run   = 1'b1;
         pend_count = b[5:0];
         return;
      end
      count      = pend_run ? pend_count : 1;
      pend_run   = 1'b0;
      pend_count = '0;
      if (count > left_bytes) begin
         flag_error(STATUS_OVERFLOW);
         return;
      end
      vis = (geo_width < geo_stride) ? geo_width[15:0] : geo_stride;
      for (int unsigned k = 0; k < count; k++) begin
         if (col_pos < vis)
            new_pixels.push_back({b,
               (32'(col_pos) + 1 == 32'(vis)) && (left_bytes == 32'(geo_stride - col_pos)),
               STATUS_PIXEL, 1'b0});
         left_bytes--;
         col_pos++;
         if (col_pos >= geo_stride) col_pos = '0;
      end
      if (left_bytes == 0) begin
         img_complete = 1'b1;
      end else if (fin) begin
         flag_error(STATUS_TRUNC_IMAGE);
         return;
      end
      if (new_pixels.size() > 0) new_pixels[new_pixels.size() - 1].run_last = 1'b1;
   endfunction

   // Offer one byte in the sender's burst pattern and record what it should give.
   task automatic push_byte(input logic [7:0] b, input logic fin, input bit typed = 1'b0,
                            input int n_typed = 0, input pixel_item_type item = '0);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= b;
      req_if.final_byte <= fin;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      expand_byte(b, fin);
      if (typed) begin
         if (n_typed > 0) expected_pixels.push_back(item);
      end else begin
         foreach (new_pixels[k]) expected_pixels.push_back(new_pixels[k]);
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [16:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      set_register(idx, value);
   endtask

   // Let the decoder drain and go idle, then load a new geometry.
   task automatic apply_geometry(input logic [16:0] w, input logic [16:0] s,
                                 input logic [16:0] h);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      write_register(REG_IMAGE_WIDTH, w);
      write_register(REG_LINE_STRIDE, s);
      write_register(REG_IMAGE_HEIGHT, h);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic void plan_byte(input logic [7:0] b, input logic fin);
      plan.push_back('{ROW_PREDICT, b, fin, 0, '0, '0, '0, '0});
   endfunction

   function automatic void plan_typed(input logic [7:0] b, input logic fin, input int n,
                                      input pixel_item_type item);
      plan.push_back('{ROW_TYPED, b, fin, n, item, '0, '0, '0});
   endfunction

   function automatic void plan_geom(input logic [16:0] w, input logic [16:0] s,
                                     input logic [16:0] h);
      plan.push_back('{ROW_GEOM, '0, 1'b0, 0, '0, w, s, h});
   endfunction

   // One image, with random geometry unless under pressure: mostly well formed, some with a fault.
   task automatic run_random_image(input bit pressure);
      logic [16:0] w, s, h;
      longint left;
      int cap, c, step, break_step;
      bit hit, fin_mark;
      fault_type fault;
      if (pressure) begin
         w = 17'd8; s = 17'd8; h = 17'd4;
      end else if ($urandom_range(0, 9) == 0) begin
         w = $urandom_range(0, 1) ? 17'h10000 : 17'd1;
         s = 17'd65535;
         h = $urandom_range(0, 1) ? 17'h10000 : 17'd1;
      end else begin
         w = $urandom_range(1, 12);
         s = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(1, w))
                                         : w + 17'($urandom_range(0, 4));
         h = $urandom_range(1, 6);
      end
      apply_geometry(w, s, h);
      left       = longint'(h) * longint'(s);
      fault      = ($urandom_range(0, 9) < 7 || pressure) ? FAULT_NONE
                                                          : fault_type'($urandom_range(1, 4));
      if (left > 4096 && fault == FAULT_NONE) fault = FAULT_EARLY_FINAL;
      break_step = $urandom_range(0, 8);
      fin_mark   = ($urandom_range(0, 3) != 0);
      step       = 0;
      hit        = 1'b0;
      if (pressure) hold_off_request = 1'b1;

      while (left > 0 && !hit) begin
         cap = (left < 63) ? int'(left) : 63;
         if (fault != FAULT_NONE && step == break_step) begin
            hit = 1'b1;
            case (fault)
               FAULT_ZERO_RUN: push_byte(RUN_MARK, 1'($urandom_range(0, 1)));
               FAULT_TRUNC_RUN: push_byte(RUN_MARK | 8'($urandom_range(1, 63)), 1'b1);
               FAULT_OVERFLOW: begin
                  if (left < 63) begin
                     c = $urandom_range(int'(left) + 1, 63);
                     push_byte(RUN_MARK | 8'(c), 1'b0);
                     push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                  end else begin
                     push_byte(RUN_MARK, 1'b0);
                  end
               end
               default: begin
                  // Final flag on a byte that leaves the image short.
                  if (left > 1) begin
                     c = $urandom_range(1, (cap < left) ? cap : cap - 1);
                     if (c == 1) begin
                        push_byte(8'($urandom_range(0, 8'hbf)), 1'b1);
                     end else begin
                        push_byte(RUN_MARK | 8'(c), 1'b0);
                        push_byte(8'($urandom_range(0, 255)), 1'b1);
                     end
                  end else begin
                     push_byte(RUN_MARK | 8'd1, 1'b1);
                  end
               end
            endcase
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               c = 1;
               push_byte(8'($urandom_range(0, 8'hbf)), fin_mark && left == 1);
            end else begin
               c = $urandom_range(1, cap);
               push_byte(RUN_MARK | 8'(c), 1'b0);
               push_byte(8'($urandom_range(0, 255)), fin_mark && left == c);
            end
            left -= c;
            step++;
         end
      end
      // Trailing bytes after completion or an error are ignored.
      repeat ($urandom_range(0, 2))
         push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // Receiver: ready follows changing patterns, with one long hold-off on request.
   initial begin : receiver
      int mode, mode_left;
      mode = 0;
      mode_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Compare each accepted result item with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      pixel_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("result item arrived with nothing expected");
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_if.pixel_value !== want.pixel)
               report_mismatch($sformatf("pixel_value %h, expected %h",
                                         rsp_if.pixel_value, want.pixel));
            if (rsp_if.image_end !== want.img_end)
               report_mismatch($sformatf("image_end %b, expected %b",
                                         rsp_if.image_end, want.img_end));
            if (rsp_if.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_if.status, want.status));
            if (rsp_if.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %b, expected %b",
                                         rsp_if.run_last, want.run_last));
         end
      end
   end

   // Hard stop if the decoder hangs.
   initial begin : watchdog
      #18_000_000;
      $display("[pcx_rle_pixel_decoder] ERROR");
      $finish;
   end

   // Main stimulus: directed plan, then random images.
   initial begin : stimulus
      int directed_count;
      req_if.valid      = 1'b0;
      req_if.data_byte  = '0;
      req_if.final_byte = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      geo_width  = 17'd1;
      geo_stride = 16'd1;
      geo_height = 17'd1;
      restart_image();

      // After reset the image is one pixel; it completes and then ignores input.
      plan_typed(8'h00, 1'b0, 1, {8'h00, 1'b1, STATUS_PIXEL, 1'b1});
      plan_typed(8'hff, 1'b1, 0, '0);
      // Zero run count, then input ignored after the error.
      plan_geom(17'd4, 17'd6, 17'd2);
      plan_typed(8'hc0, 1'b0, 1, {8'h00, 1'b0, STATUS_ZERO_RUN, 1'b1});
      plan_typed(8'h55, 1'b0, 0, '0);
      // Run prefix as the final byte.
      plan_geom(17'd4, 17'd6, 17'd2);
      plan_typed(8'hc1, 1'b1, 1, {8'h00, 1'b0, STATUS_TRUNC_RUN, 1'b1});
      // Literals, a run of a prefix-looking byte into padding, then a run overflow.
      plan_geom(17'd4, 17'd6, 17'd2);
      plan_byte(8'hbf, 1'b0);
      plan_byte(8'h7f, 1'b0);
      plan_byte(8'hc3, 1'b0);
      plan_byte(8'hc0, 1'b0);
      plan_byte(8'hff, 1'b0);
      plan_typed(8'h12, 1'b0, 1, {8'h00, 1'b0, STATUS_OVERFLOW, 1'b1});
      // A full line by one run, then the final flag with the image short.
      plan_geom(17'd4, 17'd6, 17'd2);
      plan_byte(8'hc6, 1'b0);
      plan_byte(8'haa, 1'b0);
      plan_byte(8'h01, 1'b1);
      // Width above stride: every column is visible; final flag on completion.
      plan_geom(17'd3, 17'd2, 17'd2);
      plan_byte(8'hc4, 1'b0);
      plan_byte(8'h80, 1'b1);
      plan_typed(8'h3c, 1'b1, 0, '0);
      // Largest geometry: a longest run, then a short image.
      plan_geom(17'h10000, 17'd65535, 17'h10000);
      plan_byte(8'hff, 1'b0);
      plan_byte(8'h00, 1'b0);
      plan_byte(8'h40, 1'b1);
      // Widest padding: one visible column, a first run that covers it, then a run on padding only.
      plan_geom(17'd1, 17'd65535, 17'd1);
      plan_byte(8'hc5, 1'b0);
      plan_byte(8'h11, 1'b0);
      plan_byte(8'hc2, 1'b0);
      plan_byte(8'h22, 1'b0);
      plan_byte(8'h7e, 1'b1);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         case (plan[k].kind)
            ROW_GEOM:  apply_geometry(plan[k].w, plan[k].s, plan[k].h);
            ROW_TYPED: push_byte(plan[k].data, plan[k].fin, 1'b1, plan[k].n_typed,
                                 plan[k].typed_item);
            default:   push_byte(plan[k].data, plan[k].fin);
         endcase
      end
      directed_count = bytes_sent;

      run_random_image(1'b1);
      while (bytes_sent < directed_count + 250) run_random_image(1'b0);

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0)
         $display("[pcx_rle_pixel_decoder] OK");
      else
         $display("[pcx_rle_pixel_decoder] ERROR");
      $finish;
   end

endmodule
